FILE: rtl/lapedge_pkg.sv
package lapedge_pkg;

    // Width of the frame dimension registers and of the config data bus
    localparam int DIM_W = 13;
    localparam int THR_W = 8;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [DIM_W-1:0] WIDTH_RESET = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [THR_W-1:0] THRESH_RESET = 8'd128;

    // Q16 luma weights, they sum to 65536
    localparam logic [15:0] W_RED = 16'd19595;
    localparam logic [15:0] W_GREEN = 16'd38470;
    localparam logic [15:0] W_BLUE = 16'd7471;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2
    } cfg_index_t;

    // One line memory word: the row above and the middle row at one column
    typedef struct packed {
        logic [7:0] upper;
        logic [7:0] middle;
    } line_entry_t;

endpackage

FILE: rtl/laplacian_edge_threshold.sv
// A result passes through the stage 1, stage 2 and output registers after the item completing it
//   (pixel one row below, or a drain item) is accepted; a stall on the result side holds it.
// Throughput: one item per clock while pix_stall is low; the line memory serves one read per item
//   and one write per pixel, with the right-hand column fetched one item ahead.
// Reset: counters, stage valids and configuration registers return to defaults; line memory is not cleared.
module laplacian_edge_threshold
    import lapedge_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_stall,
    input  logic                func,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    output logic                res_valid,
    input  logic                res_stall,
    output logic                edge_on,
    output logic                last_of_frame,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [DIM_W-1:0]    cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = (AW + 1 > DIM_W) ? AW + 1 : DIM_W;
    localparam int HW = DIM_W;

    typedef struct packed {
        logic           pix;
        logic           has_res;
        logic           up_is_c;
        logic           last;
        logic           use_right;
        logic           c_zero;
        logic [AW-1:0]  col;
        logic [AW-1:0]  nxt;
        logic [23:0]    prod_r;
        logic [23:0]    prod_g;
        logic [23:0]    prod_b;
    } s1_t;

    typedef struct packed {
        logic           has_res;
        logic           last;
        logic [7:0]     centre;
        logic [7:0]     up;
        logic [7:0]     down;
        logic [7:0]     left;
        logic [7:0]     right;
    } s2_t;

    // Configuration
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [THR_W-1:0] thresh_reg;
    logic             cfg_wr;
    logic             cfg_dim_wr;

    // Frame position
    logic [AW-1:0] col_reg, col_next;
    logic [AW-1:0] drain_reg, drain_next;
    logic [HW-1:0] row_reg, row_next;

    // Pipeline
    logic        s1_valid_reg;
    s1_t         s1_reg;
    logic        s2_valid_reg;
    s2_t         s2_reg;
    logic        res_valid_reg;
    logic        edge_reg;
    logic        last_reg;
    line_entry_t cur_reg;
    logic [7:0]  left_reg;

    // Line memory
    line_entry_t line_mem [MAX_WIDTH];
    line_entry_t rd_data_reg;
    line_entry_t fwd_data_reg;
    logic        fwd_hit_reg;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    line_entry_t wr_data;
    line_entry_t rd_eff;

    logic [CW-1:0] width_ext;
    logic [CW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic          accept;
    logic          is_pix;
    logic          pix_ok;
    logic          drain_ok;
    logic          item_real;
    logic [AW-1:0] c0;
    logic [CW-1:0] c0_plus1;
    logic          c0_has_right;
    s1_t           s1_next;
    logic          out_load_ok;
    logic          s2_adv;
    logic          s1_adv;
    logic          s1_leave;

    logic [23:0]   luma_sum;
    logic [7:0]    gray;
    s2_t           s2_next;
    logic signed [10:0] lap;
    logic [7:0]    level;

    assign cfg_ready = 1'b1;
    assign cfg_wr = cfg_valid && cfg_ready;
    assign cfg_dim_wr = cfg_wr && ((cfg_index == CFG_FRAME_WIDTH) ||
                                   (cfg_index == CFG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:    width_reg <= cfg_data;
                CFG_FRAME_HEIGHT:   height_reg <= cfg_data;
                CFG_EDGE_THRESHOLD: thresh_reg <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    // Effective frame size
    always_comb
    begin
        width_ext = CW'(width_reg);
        if (width_reg == '0)
            eff_w = CW'(1);
        else if (width_ext > CW'(MAX_WIDTH))
            eff_w = CW'(MAX_WIDTH);
        else
            eff_w = width_ext;

        if (height_reg == '0)
            eff_h = HW'(1);
        else if (height_reg > HW'(MAX_HEIGHT))
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = height_reg;
    end

    // Stage advance chain, output register first
    assign out_load_ok = !res_valid_reg || !res_stall;
    assign s2_adv = !s2_valid_reg || !s2_reg.has_res || out_load_ok;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign pix_stall = !s1_adv;
    assign accept = pix_valid && !pix_stall;
    assign s1_leave = s1_valid_reg && s1_adv;

    // Item classification and column lookahead
    always_comb
    begin
        is_pix = (func == FUNC_PIXEL);
        pix_ok = is_pix && (row_reg < eff_h);
        drain_ok = !is_pix && (row_reg >= eff_h);
        item_real = pix_ok || drain_ok;
        c0 = is_pix ? col_reg : drain_reg;
        c0_plus1 = CW'(c0) + CW'(1);
        c0_has_right = (c0_plus1 < eff_w);

        s1_next.pix = is_pix;
        s1_next.has_res = drain_ok || (row_reg != '0);
        s1_next.up_is_c = is_pix ? (row_reg == HW'(1)) : (eff_h == HW'(1));
        s1_next.last = drain_ok && !c0_has_right;
        s1_next.use_right = c0_has_right;
        s1_next.c_zero = (c0 == '0);
        s1_next.col = c0;
        s1_next.nxt = c0_has_right ? (c0 + AW'(1)) : '0;
        s1_next.prod_r = 24'(W_RED) * 24'(red);
        s1_next.prod_g = 24'(W_GREEN) * 24'(green);
        s1_next.prod_b = 24'(W_BLUE) * 24'(blue);

        rd_en = accept && item_real;
        rd_addr = s1_next.nxt;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        drain_next = drain_reg;
        if (cfg_dim_wr)
        begin
            col_next = '0;
            row_next = '0;
            drain_next = '0;
        end
        else if (accept && pix_ok)
        begin
            if (c0_has_right)
                col_next = c0 + AW'(1);
            else
            begin
                col_next = '0;
                row_next = row_reg + HW'(1);
            end
        end
        else if (accept && drain_ok)
        begin
            if (c0_has_right)
                drain_next = c0 + AW'(1);
            else
            begin
                col_next = '0;
                row_next = '0;
                drain_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            drain_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            drain_reg <= drain_next;
        end
    end

    // Line memory: write the leaving pixel's column, read the next column ahead
    assign wr_en = s1_leave && s1_reg.pix;
    assign wr_addr = s1_reg.col;
    assign wr_data = '{upper: cur_reg.middle, middle: gray};
    assign rd_eff = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= line_mem[rd_addr];
    end

    // Catch a read of the entry written at the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_hit_reg <= 1'b0;
        else if (rd_en)
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            fwd_data_reg <= wr_data;
    end

    // Stage 1: gray level and window assembly
    always_comb
    begin
        luma_sum = s1_reg.prod_r + s1_reg.prod_g + s1_reg.prod_b;
        gray = luma_sum[23:16];
        s2_next.has_res = s1_reg.has_res;
        s2_next.last = s1_reg.last;
        s2_next.centre = cur_reg.middle;
        s2_next.up = s1_reg.up_is_c ? cur_reg.middle : cur_reg.upper;
        s2_next.down = s1_reg.pix ? gray : cur_reg.middle;
        s2_next.left = s1_reg.c_zero ? cur_reg.middle : left_reg;
        s2_next.right = s1_reg.use_right ? rd_eff.middle : cur_reg.middle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= accept && item_real;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
            if (out_load_ok)
                res_valid_reg <= s2_valid_reg && s2_reg.has_res;
            if (s1_leave && s1_reg.has_res)
                left_reg <= cur_reg.middle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            s1_reg <= s1_next;
        // Advance the current column; a single-column row re-reads its own write
        if (s1_leave)
        begin
            if (s1_reg.pix && (s1_reg.nxt == s1_reg.col))
                cur_reg <= wr_data;
            else
                cur_reg <= rd_eff;
        end
        if (s2_adv && s1_valid_reg)
            s2_reg <= s2_next;
        if (out_load_ok && s2_valid_reg && s2_reg.has_res)
        begin
            edge_reg <= (level > thresh_reg);
            last_reg <= s2_reg.last;
        end
    end

    // Stage 2: five-point Laplacian, clamp, threshold
    always_comb
    begin
        lap = $signed({1'b0, s2_reg.centre, 2'b00})
            - $signed({3'b000, s2_reg.up})
            - $signed({3'b000, s2_reg.down})
            - $signed({3'b000, s2_reg.left})
            - $signed({3'b000, s2_reg.right});
        if (lap < 0)
            level = 8'd0;
        else if (lap > 11'sd255)
            level = 8'd255;
        else
            level = lap[7:0];
    end

    assign res_valid = res_valid_reg;
    assign edge_on = edge_reg;
    assign last_of_frame = last_reg;

endmodule

FILE: rtl/lapedge_checker.sv
module lapedge_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             pix_stall,
    input logic             res_valid,
    input logic             res_stall,
    input logic             edge_on,
    input logic             last_of_frame
);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(edge_on) && $stable(last_of_frame))
        else $error("stalled result changed");

    // Input backs up only behind a result that is waiting to be taken
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> res_valid && res_stall)
        else $error("input stalled while result side is free");

endmodule

bind laplacian_edge_threshold lapedge_checker u_lapedge_checker (.*);

FILE: test/laplacian_edge_threshold_tb.sv
`timescale 1ns / 100ps

module laplacian_edge_threshold_tb;
    import lapedge_pkg::*;

    localparam int LINE_DEPTH = 4096;
    localparam int IDLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1500;
    localparam logic [1:0] CFG_NO_REG = 2'd3;

    typedef struct packed {
        logic edge_on;
        logic last_of_frame;
    } edge_result_t;

    typedef enum logic [1:0] {
        COLOR_RANDOM,
        COLOR_EXTREME,
        COLOR_SMOOTH
    } color_mode_t;

    class edge_scoreboard;
        logic [7:0] upper_gray [LINE_DEPTH];
        logic [7:0] middle_gray [LINE_DEPTH];
        logic [7:0] left_gray;
        int unsigned col_idx;
        int unsigned row_idx;
        int unsigned drain_idx;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        logic [THR_W-1:0] thresh_reg;
        edge_result_t expected_edges [$];
        int unsigned errors;

        function new();
            foreach (upper_gray[i])
            begin
                upper_gray[i] = '0;
                middle_gray[i] = '0;
            end
            left_gray = '0;
            col_idx = 0;
            row_idx = 0;
            drain_idx = 0;
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            thresh_reg = THRESH_RESET;
            errors = 0;
        endfunction

        static function int unsigned clamp_dim(int unsigned v);
            if (v < 1)
                return 1;
            if (v > LINE_DEPTH)
                return LINE_DEPTH;
            return v;
        endfunction

        function logic laplacian_edge(int centre, int up, int down, int left, int right);
            int level;
            level = 4 * centre - up - down - left - right;
            if (level < 0)
                level = 0;
            if (level > 255)
                level = 255;
            return level > int'(thresh_reg);
        endfunction

        function void row_window(int unsigned c, int unsigned w,
                                 output int centre, output int left, output int right);
            centre = middle_gray[c];
            left = (c == 0) ? centre : int'(left_gray);
            right = (c + 1 < w) ? int'(middle_gray[c + 1]) : centre;
        endfunction

        function void write_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
            case (cfg_index_t'(idx))
                CFG_FRAME_WIDTH: width_reg = val;
                CFG_FRAME_HEIGHT: height_reg = val;
                CFG_EDGE_THRESHOLD:
                begin
                    thresh_reg = val[THR_W-1:0];
                    return;
                end
                default: return;
            endcase
            // new geometry restarts the frame
            col_idx = 0;
            row_idx = 0;
            drain_idx = 0;
        endfunction

        function void note_item(logic fn, logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned gray;
            int centre;
            int left;
            int right;
            int up;
            edge_result_t res;
            w = clamp_dim(width_reg);
            h = clamp_dim(height_reg);
            if (fn == FUNC_PIXEL)
            begin
                if (row_idx >= h)
                    return;
                c = (col_idx >= w) ? w - 1 : col_idx;
                gray = (32'(W_RED) * r + 32'(W_GREEN) * g + 32'(W_BLUE) * b) >> 16;
                if (row_idx >= 1)
                begin
                    row_window(c, w, centre, left, right);
                    up = (row_idx == 1) ? centre : int'(upper_gray[c]);
                    res.edge_on = laplacian_edge(centre, up, int'(gray), left, right);
                    res.last_of_frame = 1'b0;
                    expected_edges.insert(expected_edges.size(), res);
                    left_gray = centre[7:0];
                end
                upper_gray[c] = middle_gray[c];
                middle_gray[c] = gray[7:0];
                col_idx = c + 1;
                if (col_idx >= w)
                begin
                    col_idx = 0;
                    row_idx++;
                end
            end
            else
            begin
                if (row_idx < h)
                    return;
                c = (drain_idx >= w) ? w - 1 : drain_idx;
                row_window(c, w, centre, left, right);
                up = (h == 1) ? centre : int'(upper_gray[c]);
                res.edge_on = laplacian_edge(centre, up, centre, left, right);
                res.last_of_frame = (c + 1 >= w);
                expected_edges.insert(expected_edges.size(), res);
                left_gray = centre[7:0];
                if (res.last_of_frame)
                begin
                    row_idx = 0;
                    col_idx = 0;
                    drain_idx = 0;
                end
                else
                    drain_idx = c + 1;
            end
        endfunction

        function void check_result(logic e, logic l);
            edge_result_t exp_res;
            if (expected_edges.size() == 0)
            begin
                $display("%0t: result with nothing expected: expected none, %s %0b %s %0b",
                         $time, "actual edge_on", e, "last_of_frame", l);
                errors++;
                return;
            end
            exp_res = expected_edges.pop_front();
            if (e !== exp_res.edge_on)
            begin
                $display("%0t: edge_on expected %0b actual %0b", $time, exp_res.edge_on, e);
                errors++;
            end
            if (l !== exp_res.last_of_frame)
            begin
                $display("%0t: last_of_frame expected %0b actual %0b",
                         $time, exp_res.last_of_frame, l);
                errors++;
            end
        endfunction

        function int pending();
            return expected_edges.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_stall;
    logic func = FUNC_PIXEL;
    logic [7:0] red = '0;
    logic [7:0] green = '0;
    logic [7:0] blue = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic edge_on;
    logic last_of_frame;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [DIM_W-1:0] cfg_data = '0;

    edge_scoreboard sb;
    bit quiet_mode = 1'b0;
    bit pause_owed = 1'b0;
    int unsigned well_formed = 0;

    laplacian_edge_threshold i_dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(edge_on, last_of_frame);
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    initial
    begin : rx_stall_gen
        int unsigned run;
        int unsigned hold;
        forever
        begin
            run = $urandom_range(1, 12);
            repeat (run) @(negedge clk) res_stall <= 1'b0;
            hold = idle_len();
            repeat (hold) @(negedge clk) res_stall <= 1'b1;
        end
    end

    task automatic send_item(logic fn, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned gap;
        @(negedge clk);
        pix_valid <= 1'b1;
        func <= fn;
        red <= r;
        green <= g;
        blue <= b;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        sb.note_item(fn, r, g, b);
        gap = idle_len();
        if (gap > 0)
        begin
            @(negedge clk) pix_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_pixel(color_mode_t mode);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        case (mode)
            COLOR_EXTREME:
            begin
                r = $urandom_range(0, 1) ? 8'hff : 8'h00;
                // mostly gray so that black and white dominate the image
                if ($urandom_range(0, 3) != 0)
                begin
                    g = r;
                    b = r;
                end
                else
                begin
                    g = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    b = $urandom_range(0, 1) ? 8'hff : 8'h00;
                end
            end
            COLOR_SMOOTH:
            begin
                r = 8'($urandom_range(100, 140));
                g = 8'($urandom_range(100, 140));
                b = 8'($urandom_range(100, 140));
            end
            default:
            begin
                r = 8'($urandom_range(0, 255));
                g = 8'($urandom_range(0, 255));
                b = 8'($urandom_range(0, 255));
            end
        endcase
        send_item(FUNC_PIXEL, r, g, b);
    endtask

    task automatic send_drain();
        send_item(FUNC_DRAIN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic release_sender();
        if (pix_valid)
            @(negedge clk) pix_valid <= 1'b0;
    endtask

    task automatic wait_results();
        release_sender();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [DIM_W-1:0] w_val, logic [DIM_W-1:0] h_val,
                             logic [THR_W-1:0] thr);
        wait_results();
        // the last pixel of an aborted row may still be in flight
        repeat (IDLE_CYCLES) @(posedge clk);
        write_reg(CFG_FRAME_WIDTH, w_val);
        write_reg(CFG_FRAME_HEIGHT, h_val);
        write_reg(CFG_EDGE_THRESHOLD, {5'($urandom_range(0, 31)), thr});
    endtask

    task automatic send_frame(int unsigned w, int unsigned h, color_mode_t mode,
                              bit noisy, bit abort);
        int unsigned n_px;
        int unsigned k;
        n_px = w * h;
        for (k = 0; k < n_px; k++)
        begin
            if (abort && k == n_px / 2 + 1)
                return;
            // drain before the frame is complete: ignored
            if (noisy && $urandom_range(0, 99) < 3)
                send_drain();
            if (k >= w && (pause_owed || $urandom_range(0, 299) == 0))
            begin
                pause_owed = 1'b0;
                wait_results();
            end
            send_pixel(mode);
            well_formed++;
        end
        // pixels past the frame end: ignored
        if (noisy && $urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 2)) send_pixel(mode);
        for (k = 0; k < w; k++)
        begin
            if (noisy && $urandom_range(0, 99) < 3)
                send_pixel(mode);
            send_drain();
            well_formed++;
        end
    endtask

    initial
    begin : main_seq
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned frames;
        logic [DIM_W-1:0] w_val;
        logic [DIM_W-1:0] h_val;
        logic [THR_W-1:0] thr;
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // a small frame of black and white at threshold zero
        configure(13'd3, 13'd3, 8'd0);
        send_frame(3, 3, COLOR_EXTREME, 1'b0, 1'b0);

        // zero size means a single pixel; stray items around it are dropped
        configure(13'd0, 13'd0, 8'd255);
        send_drain();
        send_item(FUNC_PIXEL, 8'hff, 8'hff, 8'hff);
        send_item(FUNC_PIXEL, 8'h00, 8'h00, 8'h00);
        send_drain();

        configure(13'd2, 13'd2, 8'd128);
        send_frame(2, 2, COLOR_EXTREME, 1'b0, 1'b0);

        // oversize registers: a tall frame keeps running, a wide row does not wrap early
        configure(13'd2, 13'd8191, 8'($urandom_range(0, 255)));
        repeat (200) send_pixel(COLOR_RANDOM);
        configure(13'd8191, 13'd2, 8'($urandom_range(0, 255)));
        repeat (100) send_pixel(COLOR_RANDOM);
        send_drain();

        pause_owed = 1'b1;
        well_formed = 0;
        while (well_formed < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 5);
            end
            else if (r < 92)
            begin
                w = $urandom_range(9, 40);
                h = $urandom_range(1, 4);
            end
            else
            begin
                w = $urandom_range(41, 200);
                h = $urandom_range(1, 3);
            end
            w_val = DIM_W'(w);
            h_val = DIM_W'(h);
            if (w == 1 && $urandom_range(0, 1))
                w_val = '0;
            if (h == 1 && $urandom_range(0, 1))
                h_val = '0;
            r = $urandom_range(0, 99);
            thr = (r < 10) ? 8'd0 : (r < 20) ? 8'd255 : 8'($urandom_range(0, 255));
            quiet_mode = ($urandom_range(0, 4) == 0);
            configure(w_val, h_val, thr);
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_NO_REG, 13'($urandom_range(0, 8191)));
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
                send_frame(w, h, color_mode_t'($urandom_range(0, 2)),
                           $urandom_range(0, 99) < 40,
                           f == frames - 1 && w * h >= 4 && $urandom_range(0, 99) < 8);
        end

        wait_results();
        repeat (IDLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
